// ===== hdl/lbps_pkg.sv =====
package lbps_pkg;

    localparam int BYTE_W = 8;
    localparam int TICK_W = 15;
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam int CNT_W  = 4;

    localparam logic [BYTE_W-1:0] BRIGHT_FULL = 8'hff;

    localparam logic [BYTE_W-1:0] RST_BRIGHTNESS = 8'd255;
    localparam logic [TICK_W-1:0] RST_ONE_HIGH   = 15'd32;
    localparam logic [TICK_W-1:0] RST_ONE_LOW    = 15'd18;
    localparam logic [TICK_W-1:0] RST_ZERO_HIGH  = 15'd16;
    localparam logic [TICK_W-1:0] RST_ZERO_LOW   = 15'd34;
    localparam logic [TICK_W-1:0] RST_RESET      = 15'd2000;

    // symbol counter: 0..7 data bits, 8 is the end-of-frame reset symbol
    localparam logic [2:0]       LAST_BIT   = 3'd7;
    localparam logic [CNT_W-1:0] RESET_SLOT = 4'd8;

    typedef enum logic [2:0] {
        REG_BRIGHTNESS = 3'd0,
        REG_ONE_HIGH   = 3'd1,
        REG_ONE_LOW    = 3'd2,
        REG_ZERO_HIGH  = 3'd3,
        REG_ZERO_LOW   = 3'd4,
        REG_RESET      = 3'd5
    } reg_idx_t;

endpackage

// ===== hdl/led_byte_to_pulse_symbols.sv =====
// Channel  | Handshake          | Payload
// ---------+--------------------+---------------------------------------------------
// input    | s_valid / s_ready  | s_color_byte[7:0], s_frame_last
// result   | m_valid / m_ready  | m_first_duration, m_first_level, m_second_duration,
//          |                    | m_second_level, m_run_last
// config   | APB (psel/penable) | paddr[4:2] selects register, pwdata, prdata
//
// One byte gives 8 result symbols, 9 when s_frame_last is set: the symbol counter
// moves one symbol per cycle into the result register unless m_ready stalls it.
// The next byte is accepted in the cycle its predecessor's final symbol is sent.
// An accepted byte is held in the byte register; its first symbol then passes through the result register to m_valid.
// aresetn is synchronous, active low; it loads the register reset values.
// m_ready low while m_valid is high freezes the result register and the symbol counter.
module led_byte_to_pulse_symbols (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lbps_pkg::APB_AW-1:0]    paddr,
    input  logic [lbps_pkg::APB_DW-1:0]    pwdata,
    output logic [lbps_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [lbps_pkg::BYTE_W-1:0]    s_color_byte,
    input  logic                           s_frame_last,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [lbps_pkg::TICK_W-1:0]    m_first_duration,
    output logic                           m_first_level,
    output logic [lbps_pkg::TICK_W-1:0]    m_second_duration,
    output logic                           m_second_level,
    output logic                           m_run_last
);
    import lbps_pkg::*;

    logic [BYTE_W-1:0] brightness_reg;
    logic [TICK_W-1:0] one_high_reg, one_low_reg, zero_high_reg, zero_low_reg, reset_reg;

    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              last_reg;
    logic              hold_valid_reg, hold_valid_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              m_valid_reg;
    logic [TICK_W-1:0] first_dur_reg, second_dur_reg;
    logic              first_lvl_reg, run_last_reg;

    logic [2*BYTE_W-1:0] product;
    logic              cfg_wr, accept, out_adv, emit, emit_final, is_reset_sym, bit_val;
    logic [2:0]        bit_idx;
    reg_idx_t          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_BRIGHTNESS: prdata = APB_DW'(brightness_reg);
            REG_ONE_HIGH:   prdata = APB_DW'(one_high_reg);
            REG_ONE_LOW:    prdata = APB_DW'(one_low_reg);
            REG_ZERO_HIGH:  prdata = APB_DW'(zero_high_reg);
            REG_ZERO_LOW:   prdata = APB_DW'(zero_low_reg);
            REG_RESET:      prdata = APB_DW'(reset_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= RST_BRIGHTNESS;
            one_high_reg   <= RST_ONE_HIGH;
            one_low_reg    <= RST_ONE_LOW;
            zero_high_reg  <= RST_ZERO_HIGH;
            zero_low_reg   <= RST_ZERO_LOW;
            reset_reg      <= RST_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_BRIGHTNESS: brightness_reg <= pwdata[BYTE_W-1:0];
                REG_ONE_HIGH:   one_high_reg   <= pwdata[TICK_W-1:0];
                REG_ONE_LOW:    one_low_reg    <= pwdata[TICK_W-1:0];
                REG_ZERO_HIGH:  zero_high_reg  <= pwdata[TICK_W-1:0];
                REG_ZERO_LOW:   zero_low_reg   <= pwdata[TICK_W-1:0];
                REG_RESET:      reset_reg      <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // brightness scale on the way into the byte register
    assign product   = s_color_byte * brightness_reg;
    assign byte_next = (brightness_reg == BRIGHT_FULL) ? s_color_byte
                                                       : product[2*BYTE_W-1:BYTE_W];

    assign out_adv      = !m_valid_reg || m_ready;
    assign emit         = hold_valid_reg && out_adv;
    assign is_reset_sym = cnt_reg[CNT_W-1];
    assign bit_idx      = LAST_BIT - cnt_reg[2:0];
    assign bit_val      = byte_reg[bit_idx];
    assign emit_final   = emit && (is_reset_sym || (cnt_reg[2:0] == LAST_BIT && !last_reg));
    assign s_ready      = !hold_valid_reg || emit_final;
    assign accept       = s_valid && s_ready;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        cnt_next        = cnt_reg;
        if (accept) begin
            hold_valid_next = 1'b1;
            cnt_next        = '0;
        end else if (emit_final) begin
            hold_valid_next = 1'b0;
            cnt_next        = '0;
        end else if (emit) begin
            cnt_next        = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            cnt_reg        <= cnt_next;
            if (out_adv) begin
                m_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            byte_reg <= byte_next;
            last_reg <= s_frame_last;
        end
        if (emit) begin
            run_last_reg <= emit_final;
            if (is_reset_sym) begin
                first_dur_reg  <= reset_reg;
                first_lvl_reg  <= 1'b0;
                second_dur_reg <= '0;
            end else begin
                first_dur_reg  <= bit_val ? one_high_reg : zero_high_reg;
                first_lvl_reg  <= 1'b1;
                second_dur_reg <= bit_val ? one_low_reg : zero_low_reg;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_first_duration  = first_dur_reg;
    assign m_first_level     = first_lvl_reg;
    assign m_second_duration = second_dur_reg;
    assign m_second_level    = 1'b0;
    assign m_run_last        = run_last_reg;

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= RESET_SLOT)
        else $error("symbol counter beyond reset slot");

    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg && !emit_final |-> !s_ready)
        else $error("input taken while byte still being sent");

    a_reset_sym_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_first_level |-> m_run_last && m_second_duration == '0)
        else $error("reset symbol not marked final");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_final && !accept |=> !hold_valid_reg)
        else $error("byte register not released after final symbol");

endmodule
